FILE: design/lidar_point_box_crop_filter_defines.svh
// ----------------------------------------------------------------------------
// lidar point box crop filter assertion macros
// Shared concurrent assertion wrappers for the filter block.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_BOX_CROP_FILTER_DEFINES_SVH
`define LIDAR_POINT_BOX_CROP_FILTER_DEFINES_SVH

// checked on every edge outside reset
`define LPBCF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LPBCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lpbcf_pkg.sv
// ----------------------------------------------------------------------------
// lpbcf_pkg
// Types and constants shared by the lidar point box crop filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbcf_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_COEF_INDEX  = 3'd0;
  localparam logic [2:0] REG_COEF_VALUE  = 3'd1;
  localparam logic [2:0] REG_BOX_COUNT   = 3'd2;
  localparam logic [2:0] REG_CROP_ENABLE = 3'd3;
  localparam logic [2:0] REG_BYPASS      = 3'd4;

  // reject reasons
  localparam logic [1:0] REASON_KEEP = 2'd0;
  localparam logic [1:0] REASON_BOX  = 2'd1;
  localparam logic [1:0] REASON_CROP = 2'd2;

  // coefficient table layout
  localparam int XF_COUNT   = 12;
  localparam int CROP_BASE  = 12;
  localparam int CROP_COUNT = 6;
  localparam int BOX_BASE   = 18;
  localparam int BOX_STRIDE = 15;

  // accumulator widths: three 64-bit and three 65-bit products
  localparam int XF_ACC_W  = 66;
  localparam int BOX_ACC_W = 67;

  typedef struct packed {
    logic               we;
    logic [7:0]         index;
    logic signed [31:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       start;
    logic       run;
    logic [1:0] col;
    logic [1:0] phase;
    logic       shift;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point3_t;

endpackage

`default_nettype wire

FILE: design/lpbcf_point_if.sv
// ----------------------------------------------------------------------------
// lpbcf_point_if / lpbcf_result_if
// Valid/ready channels for source points and filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpbcf_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;
  logic signed [31:0] src_z;
  logic               point_valid;

  modport source (output valid, src_x, src_y, src_z, point_valid, input ready);
  modport sink   (input valid, src_x, src_y, src_z, point_valid, output ready);
endinterface

interface lpbcf_result_if;
  logic               valid;
  logic               ready;
  logic               keep;
  logic [1:0]         reject_reason;
  logic [2:0]         hit_box;
  logic signed [31:0] filt_x;
  logic signed [31:0] filt_y;
  logic signed [31:0] filt_z;

  modport source (output valid, keep, reject_reason, hit_box, filt_x, filt_y, filt_z,
                  input ready);
  modport sink   (input valid, keep, reject_reason, hit_box, filt_x, filt_y, filt_z,
                  output ready);
endinterface

`default_nettype wire

FILE: design/lidar_point_box_crop_filter.sv
// ----------------------------------------------------------------------------
// lidar_point_box_crop_filter
// Transforms lidar points into the filter frame, culls them against oriented
// boxes and optional crop bounds.
// ----------------------------------------------------------------------------
// One point is in flight at a time. A point passes through the transform
// (one shared 32x32 multiplier, three products and a rounding step per axis),
// then the box cells (each cell owns one multiplier and works three
// columns of its rotation), then the first-hit result ripples down the cell
// chain and the result register is loaded, once any result it still holds
// has been taken. In bypass the point goes from accept straight to the
// result register. A new point is taken as soon as the previous one sits in
// the result register.
`default_nettype none
`include "lidar_point_box_crop_filter_defines.svh"

module lidar_point_box_crop_filter #(
  parameter int MAX_BOXES = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst,
  lpbcf_point_if.sink       points,
  lpbcf_result_if.source    results,
  input  wire               cfg_write,
  input  wire [2:0]         cfg_index,
  input  wire [31:0]        cfg_data
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int XW    = lpbcf_pkg::XF_ACC_W;
  localparam logic signed [XW-1:0] RND_HALF = XW'(64'd1 << (FRAC_BITS - 1));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_XF    = 3'd1;
  localparam logic [2:0] ST_BOX   = 3'd2;
  localparam logic [2:0] ST_CHAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]  state;
  logic [7:0]  coef_index;
  logic [3:0]  box_count;
  logic        crop_enable;
  logic        bypass;

  logic signed [31:0] xf_coef   [lpbcf_pkg::XF_COUNT];
  logic signed [31:0] crop_coef [lpbcf_pkg::CROP_COUNT];

  lpbcf_pkg::point3_t src;
  lpbcf_pkg::point3_t filt;
  logic               pvalid;
  logic [1:0]         row;
  logic [1:0]         phase;
  logic [1:0]         col;
  logic [CNT_W-1:0]   chain_cnt;
  logic signed [XW-1:0] acc;

  logic               out_valid;
  logic               out_keep;
  logic [1:0]         out_reason;
  logic [2:0]         out_hit;
  lpbcf_pkg::point3_t out_pt;

  lpbcf_pkg::cfg_wr_t   wr;
  lpbcf_pkg::cell_ctl_t ctl;

  logic               found_c [MAX_BOXES+1];
  logic [IDX_W-1:0]   idx_c   [MAX_BOXES+1];

  logic               accept;
  logic signed [31:0] src_sel;
  logic signed [63:0] xprod;
  logic signed [XW:0] xsum;
  logic signed [31:0] xsat;
  logic               crop_ok;
  logic               res_load;

  assign accept         = points.valid && points.ready;
  assign points.ready   = (state == ST_IDLE);
  assign results.valid  = out_valid;
  assign results.keep   = out_keep;
  assign results.reject_reason = out_reason;
  assign results.hit_box = out_hit;
  assign results.filt_x = out_pt.x;
  assign results.filt_y = out_pt.y;
  assign results.filt_z = out_pt.z;
  assign res_load       = (state == ST_FIN) && (!out_valid || results.ready);

  assign wr.we    = cfg_write && (cfg_index == lpbcf_pkg::REG_COEF_VALUE);
  assign wr.index = coef_index;
  assign wr.data  = $signed(cfg_data);

  assign ctl.start = (state == ST_XF) && (row == 2'd2) && (phase == 2'd3);
  assign ctl.run   = (state == ST_BOX);
  assign ctl.col   = col;
  assign ctl.phase = phase;
  assign ctl.shift = (state == ST_CHAIN);

  // transform datapath: r[row][phase] * src[phase], then round and add t
  always_comb begin
    case (phase)
      2'd0:    src_sel = src.x;
      2'd1:    src_sel = src.y;
      default: src_sel = src.z;
    endcase
    xprod = 64'(xf_coef[{row, phase}]) * 64'(src_sel);
    xsum  = (XW+1)'((acc + RND_HALF) >>> FRAC_BITS) + (XW+1)'(xf_coef[{row, phase}]);
    if (xsum > (XW+1)'(32'sh7fffffff)) begin
      xsat = 32'sh7fffffff;
    end else if (xsum < (XW+1)'(-33'sh80000000)) begin
      xsat = -32'sh80000000;
    end else begin
      xsat = 32'(xsum);
    end
    crop_ok = pvalid
      && filt.x >= crop_coef[0] && filt.x <= crop_coef[1]
      && filt.y >= crop_coef[2] && filt.y <= crop_coef[3]
      && filt.z >= crop_coef[4] && filt.z <= crop_coef[5];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_index  <= '0;
      box_count   <= '0;
      crop_enable <= 1'b0;
      bypass      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lpbcf_pkg::REG_COEF_INDEX:  coef_index  <= cfg_data[7:0];
        lpbcf_pkg::REG_BOX_COUNT:   box_count   <= cfg_data[3:0];
        lpbcf_pkg::REG_CROP_ENABLE: crop_enable <= cfg_data[0];
        lpbcf_pkg::REG_BYPASS:      bypass      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      if (int'(wr.index) < lpbcf_pkg::XF_COUNT) begin
        xf_coef[wr.index[3:0]] <= wr.data;
      end else if (int'(wr.index) < lpbcf_pkg::BOX_BASE) begin
        crop_coef[3'(int'(wr.index) - lpbcf_pkg::CROP_BASE)] <= wr.data;
      end
    end
  end

  // sequencer and point datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      src.x  <= points.src_x;
      src.y  <= points.src_y;
      src.z  <= points.src_z;
      filt.x <= points.src_x;
      filt.y <= points.src_y;
      filt.z <= points.src_z;
      pvalid <= points.point_valid;
    end
    if (state == ST_XF) begin
      if (phase == 2'd3) begin
        case (row)
          2'd0:    filt.x <= xsat;
          2'd1:    filt.y <= xsat;
          default: filt.z <= xsat;
        endcase
      end else begin
        acc <= (phase == 2'd0) ? XW'(xprod) : acc + XW'(xprod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      phase     <= '0;
      col       <= '0;
      chain_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          row   <= '0;
          phase <= '0;
          if (accept) begin
            state <= bypass ? ST_FIN : ST_XF;
          end
        end
        ST_XF: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            row <= row + 2'd1;
            if (row == 2'd2) begin
              state <= ST_BOX;
              col   <= '0;
            end
          end
        end
        ST_BOX: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            col <= col + 2'd1;
            if (col == 2'd2) begin
              state     <= ST_CHAIN;
              chain_cnt <= '0;
            end
          end
        end
        ST_CHAIN: begin
          chain_cnt <= chain_cnt + 1'b1;
          if (chain_cnt == CNT_W'(MAX_BOXES - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_pt <= filt;
      if (bypass) begin
        out_keep   <= 1'b1;
        out_reason <= lpbcf_pkg::REASON_KEEP;
        out_hit    <= '0;
      end else if (pvalid && found_c[MAX_BOXES]) begin
        out_keep   <= 1'b0;
        out_reason <= lpbcf_pkg::REASON_BOX;
        out_hit    <= 3'(idx_c[MAX_BOXES]);
      end else if (crop_enable && !crop_ok) begin
        out_keep   <= 1'b0;
        out_reason <= lpbcf_pkg::REASON_CROP;
        out_hit    <= '0;
      end else begin
        out_keep   <= 1'b1;
        out_reason <= lpbcf_pkg::REASON_KEEP;
        out_hit    <= '0;
      end
    end
  end

  // box cells, first hit ripples from box 0 upward
  assign found_c[0] = 1'b0;
  assign idx_c[0]   = '0;

  for (genvar b = 0; b < MAX_BOXES; b++) begin : g_cell
    lpbcf_box_cell #(
      .BOX_ID    (b),
      .FRAC_BITS (FRAC_BITS),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr        (wr),
      .ctl       (ctl),
      .filt      (filt),
      .box_count (box_count),
      .found_in  (found_c[b]),
      .idx_in    (idx_c[b]),
      .found_out (found_c[b+1]),
      .idx_out   (idx_c[b+1])
    );
  end

  `LPBCF_ASSERT(a_keep_reason, clk, rst,
    out_valid |-> (out_keep == (out_reason == lpbcf_pkg::REASON_KEEP)),
    "keep flag disagrees with reject reason")
  `LPBCF_ASSERT(a_hit_only_box, clk, rst,
    (out_valid && out_reason != lpbcf_pkg::REASON_BOX) |-> (out_hit == 3'd0),
    "hit box set without a box reject")
  `LPBCF_ASSERT(a_accept_leaves_idle, clk, rst,
    accept |=> (state != ST_IDLE),
    "sequencer stayed idle after a beat")
  `LPBCF_ASSERT_ALWAYS(a_reset_clears, clk,
    rst |=> !out_valid,
    "result valid after reset")

endmodule

`default_nettype wire

FILE: design/lpbcf_box_cell.sv
// ----------------------------------------------------------------------------
// lpbcf_box_cell
// One oriented box: holds its 15 coefficients, tests the point with one
// multiplier, then takes part in the first-hit chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbcf_box_cell #(
  parameter int BOX_ID    = 0,
  parameter int FRAC_BITS = 16,
  parameter int IDX_W     = 3
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire lpbcf_pkg::cfg_wr_t   wr,
  input  wire lpbcf_pkg::cell_ctl_t ctl,
  input  wire lpbcf_pkg::point3_t   filt,
  input  wire [3:0]                 box_count,
  input  wire                       found_in,
  input  wire [IDX_W-1:0]           idx_in,
  output logic                      found_out,
  output logic [IDX_W-1:0]          idx_out
);

  localparam int BASE = lpbcf_pkg::BOX_BASE + lpbcf_pkg::BOX_STRIDE * BOX_ID;
  localparam int AW   = lpbcf_pkg::BOX_ACC_W;
  localparam logic signed [AW-1:0] RND_HALF = AW'(64'd1 << (FRAC_BITS - 1));

  // center 0..2, rotation 3..11 row-major, half extent 12..14
  logic signed [31:0]   coef [lpbcf_pkg::BOX_STRIDE];
  logic signed [AW-1:0] acc;
  logic                 in_box;
  logic                 active;

  logic signed [31:0]   fsel;
  logic signed [32:0]   d;
  logic signed [64:0]   prod;
  logic signed [AW-1:0] loc;
  logic signed [AW-1:0] loc_abs;
  logic [3:0]           m_idx;
  logic [3:0]           wr_off;
  logic                 wr_hit;

  always_comb begin
    wr_hit = wr.we && (int'(wr.index) >= BASE) && (int'(wr.index) < BASE + 15);
    wr_off = 4'(int'(wr.index) - BASE);
    case (ctl.phase)
      2'd0:    fsel = filt.x;
      2'd1:    fsel = filt.y;
      default: fsel = filt.z;
    endcase
    // d_i = filt_i - center_i, m[i][j] with i = phase, j = col
    d     = 33'(fsel) - 33'(coef[4'(ctl.phase)]);
    m_idx = 4'(3 + 3 * int'(ctl.phase) + int'(ctl.col));
    prod  = 65'(d) * 65'(coef[m_idx]);
    loc     = (acc + RND_HALF) >>> FRAC_BITS;
    loc_abs = loc[AW-1] ? -loc : loc;
    active  = 32'(box_count) > BOX_ID;
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      coef[wr_off] <= wr.data;
    end
    if (ctl.run && ctl.phase != 2'd3) begin
      acc <= (ctl.phase == 2'd0) ? AW'(prod) : acc + AW'(prod);
    end
    if (ctl.shift) begin
      found_out <= found_in || (in_box && active);
      idx_out   <= found_in ? idx_in : IDX_W'(BOX_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_box <= 1'b0;
    end else if (ctl.start) begin
      in_box <= 1'b1;
    end else if (ctl.run && ctl.phase == 2'd3) begin
      if (loc_abs > AW'(coef[4'(12 + int'(ctl.col))])) begin
        in_box <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
